// ----- rtl/tdpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types for the trial division prime test: control states and the
// status group that the serial divider reports back to the sequencer.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIVIDE,
    ST_HOLD
  } tdpt_state_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } tdpt_div_stat_t;

endpackage

// ----- rtl/tdpt_divider.sv -----
// ----------------------------------------------------------------------------
// tdpt_divider
// Bit-serial restoring divider. One quotient bit per cycle; reports done
// with a zero-remainder flag.
// ----------------------------------------------------------------------------
module tdpt_divider #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DATA_WIDTH-1:0]       dividend,
  input  logic [DATA_WIDTH-1:0]       divisor,
  output logic [DATA_WIDTH-1:0]       quotient,
  output tdpt_pkg::tdpt_div_stat_t    stat
);
  import tdpt_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic [CW-1:0] count;
  logic          busy;
  logic          done;
  logic [W-1:0]  quo;
  logic [W-1:0]  rem;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  rem_next;

  // shift in the next dividend bit, trial subtract
  always_comb begin
    rem_sh   = {rem, quo[W-1]};
    diff     = rem_sh - {1'b0, divisor};
    ge       = ~diff[W];
    rem_next = ge ? diff[W-1:0] : rem_sh[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(DATA_WIDTH);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient      = quo;
  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);

endmodule

// ----- rtl/trial_division_prime_test.sv -----
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Negatives, 0, 1, 2 and evens are settled without division and go straight
// to the hold state. Odd values run the bit-serial divider (one bit per cycle)
// over odd divisors 3, 5, ... until one divides n or exceeds the quotient.
// Throughput: one request at a time; next request taken once the result is
// handed to the output register. Reset clears control and output valid.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] number,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         is_prime
);
  import tdpt_pkg::*;

  localparam int W = DATA_WIDTH;

  tdpt_state_t    state, state_next;
  logic [W-1:0]   n;
  logic [W-1:0]   d;
  logic [W-1:0]   quot;
  logic           res;
  logic           start;
  logic           in_acc;
  logic           out_load;
  logic           triv;
  logic           triv_res;
  logic           past_root;
  tdpt_div_stat_t stat;

  tdpt_divider #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (n),
    .divisor  (d),
    .quotient (quot),
    .stat     (stat)
  );

  assign in_acc    = in_valid && in_ready;
  assign past_root = (d > quot);

  // cases settled without any division
  always_comb begin
    triv     = 1'b1;
    triv_res = 1'b0;
    if (number[W-1]) begin
      triv_res = 1'b0;
    end else if (number[W-1:1] == '0) begin
      triv_res = 1'b0;
    end else if ($unsigned(number) == W'(2)) begin
      triv_res = 1'b1;
    end else if (!number[0]) begin
      triv_res = 1'b0;
    end else begin
      triv = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) state_next = triv ? ST_HOLD : ST_START;
      end
      ST_START: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (stat.done) state_next = (past_root || stat.rem_zero) ? ST_HOLD : ST_START;
      end
      ST_HOLD: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    start    = (state == ST_START);
    out_load = (state == ST_HOLD) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) is_prime <= res;
    if (in_acc) begin
      n   <= $unsigned(number);
      d   <= W'(3);
      res <= triv_res;
    end else if (state == ST_DIVIDE && stat.done) begin
      // divisor beyond the root: no factor found
      if (past_root) begin
        res <= 1'b1;
      end else if (stat.rem_zero) begin
        res <= 1'b0;
      end
      d <= d + W'(2);
    end
  end

endmodule
